### hw/rtl/set_assoc_cache_tag_lookup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative tag lookup
// Shorthand for clocked properties that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACTL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg
// Shared constants and types of the set-associative tag lookup.
// ----------------------------------------------------------------------------
package sactl_pkg;

    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_WIDTH  = 2'd2;

    localparam logic       POLICY_LRU  = 1'b0;
    localparam logic       POLICY_FIFO = 1'b1;
    localparam logic       CMD_ACCESS  = 1'b0;
    localparam logic       CMD_CLEAR   = 1'b1;

    localparam logic       RST_POLICY       = POLICY_LRU;
    localparam logic [3:0] RST_OFFSET_WIDTH = 4'd5;
    localparam logic [2:0] RST_INDEX_WIDTH  = 3'd6;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

endpackage

### hw/rtl/sactl_addr_split.sv
// ----------------------------------------------------------------------------
// sactl_addr_split
// Splits a byte address into set index and tag under the current field widths.
// ----------------------------------------------------------------------------
module sactl_addr_split #(
    parameter int SETS_LOG2 = 6,
    parameter int SET_W     = 6
) (
    input  logic [sactl_pkg::ADDR_W-1:0] address,
    input  logic [3:0]                   offset_width,
    input  logic [2:0]                   index_width,
    output logic [SET_W-1:0]             set_idx,
    output logic [sactl_pkg::TAG_W-1:0]  tag
);

    logic [3:0]                   ibits;
    logic [4:0]                   tag_shift;
    logic [sactl_pkg::ADDR_W-1:0] set_full;

    always_comb
    begin
        // Index widths beyond the built set count fold down to the full width.
        if ({1'b0, index_width} > 4'(SETS_LOG2))
        begin
            ibits = 4'(SETS_LOG2);
        end
        else
        begin
            ibits = {1'b0, index_width};
        end
        tag_shift = {1'b0, offset_width} + {1'b0, ibits};
        set_full  = (address >> offset_width) & ~({sactl_pkg::ADDR_W{1'b1}} << ibits);
        set_idx   = set_full[SET_W-1:0];
        tag       = address >> tag_shift;
    end

endmodule

### hw/rtl/sactl_way_ram.sv
// ----------------------------------------------------------------------------
// sactl_way_ram
// Tag and stamp memory of one way: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sactl_way_ram #(
    parameter int SETS_LOG2 = 6,
    parameter int SET_W     = 6
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [SET_W-1:0]   wr_addr,
    input  sactl_pkg::line_t   wr_data,
    input  logic               rd_en,
    input  logic [SET_W-1:0]   rd_addr,
    output sactl_pkg::line_t   rd_data
);

    localparam int DEPTH = 1 << SETS_LOG2;

    sactl_pkg::line_t mem [DEPTH];
    sactl_pkg::line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sactl_victim.sv
// ----------------------------------------------------------------------------
// sactl_victim
// Way selection: first hitting way, else first empty way, else oldest stamp.
// ----------------------------------------------------------------------------
module sactl_victim #(
    parameter int NUM_WAYS = 4,
    parameter int WAY_W    = 2
) (
    input  logic [NUM_WAYS-1:0]          valid_vec,
    input  logic [NUM_WAYS-1:0]          hit_vec,
    input  logic [sactl_pkg::STAMP_W-1:0] stamps [NUM_WAYS],
    output logic                         hit,
    output logic [WAY_W-1:0]             way
);

    localparam int LEAVES = 1 << WAY_W;
    localparam int NODES  = 2 * LEAVES - 1;

    logic [sactl_pkg::STAMP_W-1:0] node_stamp [NODES];
    logic [WAY_W-1:0]              node_way   [NODES];
    logic                          node_live  [NODES];
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              empty_way;
    logic                          any_empty;

    always_comb
    begin
        // Leaves of the minimum tree; padding leaves never win.
        for (int i = 0; i < LEAVES; i++)
        begin
            node_way[LEAVES-1+i] = WAY_W'(i);
            if (i < NUM_WAYS)
            begin
                node_stamp[LEAVES-1+i] = stamps[i];
                node_live[LEAVES-1+i]  = 1'b1;
            end
            else
            begin
                node_stamp[LEAVES-1+i] = '0;
                node_live[LEAVES-1+i]  = 1'b0;
            end
        end
        // The right child wins only on a strictly smaller stamp, so ties keep
        // the lower way.
        for (int n = LEAVES - 2; n >= 0; n--)
        begin
            if (node_live[2*n+2] && (node_stamp[2*n+2] < node_stamp[2*n+1]))
            begin
                node_stamp[n] = node_stamp[2*n+2];
                node_way[n]   = node_way[2*n+2];
            end
            else
            begin
                node_stamp[n] = node_stamp[2*n+1];
                node_way[n]   = node_way[2*n+1];
            end
            node_live[n] = node_live[2*n+1] | node_live[2*n+2];
        end
    end

    always_comb
    begin
        hit_way   = '0;
        empty_way = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_way = WAY_W'(i);
            end
            if (!valid_vec[i])
            begin
                empty_way = WAY_W'(i);
            end
        end
        any_empty = ~&valid_vec;
        hit       = |hit_vec;
        if (hit)
        begin
            way = hit_way;
        end
        else if (any_empty)
        begin
            way = empty_way;
        end
        else
        begin
            way = node_way[0];
        end
    end

endmodule

### hw/rtl/set_assoc_cache_tag_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag store of a set-associative cache with LRU or FIFO replacement.
// ----------------------------------------------------------------------------
// Accepts one request per cycle unless the input stalls and returns one result
// per request, which passes through the lookup stage into the result register.
// At the accepting edge the decoded set is read from the per-way tag memories;
// in the lookup stage all ways are compared in parallel and the way is picked,
// and as the request advances tag and stamp are written back, the counters are
// updated and the result register is loaded. The input stalls only while the
// lookup stage holds a request and a stalled result sits in the output register.
// The most recent write is forwarded to the following request, so back-to-back
// requests to the same set see it. A clear request empties all lines and zeroes
// all counters in its own single pass; no clearing sweep is needed after reset.
module set_assoc_cache_tag_lookup #(
    parameter int NUM_WAYS  = 4,
    parameter int SETS_LOG2 = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [sactl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sactl_pkg::CFG_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [sactl_pkg::ADDR_W-1:0]   address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic [1:0]                     way_used,
    output logic [sactl_pkg::CNT_W-1:0]    access_total,
    output logic [sactl_pkg::CNT_W-1:0]    hit_total,
    output logic [sactl_pkg::CNT_W-1:0]    miss_total,
    output logic                           stamp_overflow
);

    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_W     = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;
    localparam int SET_COUNT = 1 << SETS_LOG2;

    // Configuration registers.
    logic       policy_reg;
    logic [3:0] offset_w_reg;
    logic [2:0] index_w_reg;

    // Lookup stage.
    logic                          s1_valid_reg;
    logic                          s1_cmd_reg;
    logic [SET_W-1:0]              s1_set_reg;
    logic [sactl_pkg::TAG_W-1:0]   s1_tag_reg;

    // Last line write, forwarded to the request read in the same cycle.
    logic                          fwd_valid_reg;
    logic [SET_W-1:0]              fwd_set_reg;
    logic [WAY_W-1:0]              fwd_way_reg;
    sactl_pkg::line_t              fwd_line_reg;

    // Line state and counters.
    logic [NUM_WAYS-1:0]           valid_reg [SET_COUNT];
    logic [sactl_pkg::STAMP_W-1:0] stamp_cnt_reg;
    logic [sactl_pkg::CNT_W-1:0]   access_cnt_reg;
    logic [sactl_pkg::CNT_W-1:0]   hit_cnt_reg;
    logic [sactl_pkg::CNT_W-1:0]   miss_cnt_reg;
    logic                          overflow_reg;

    // Result register.
    logic                          out_valid_reg;
    logic                          hit_reg;
    logic [1:0]                    way_used_reg;
    logic [sactl_pkg::CNT_W-1:0]   access_total_reg;
    logic [sactl_pkg::CNT_W-1:0]   hit_total_reg;
    logic [sactl_pkg::CNT_W-1:0]   miss_total_reg;
    logic                          overflow_out_reg;

    logic                          advance;
    logic                          accept;
    logic                          do_access;
    logic                          do_clear;
    logic [SET_W-1:0]              in_set;
    logic [sactl_pkg::TAG_W-1:0]   in_tag;
    sactl_pkg::line_t              rd_line   [NUM_WAYS];
    sactl_pkg::line_t              eff_line  [NUM_WAYS];
    logic [sactl_pkg::STAMP_W-1:0] eff_stamp [NUM_WAYS];
    logic [NUM_WAYS-1:0]           set_valid;
    logic [NUM_WAYS-1:0]           hit_vec;
    logic                          pick_hit;
    logic [WAY_W-1:0]              pick_way;
    logic [WAY_W+1:0]              pick_way_wide;
    logic                          stamp_req;
    logic                          line_we;
    logic [sactl_pkg::STAMP_W-1:0] stamp_cnt_next;
    logic                          overflow_next;
    logic [sactl_pkg::CNT_W-1:0]   access_cnt_next;
    logic [sactl_pkg::CNT_W-1:0]   hit_cnt_next;
    logic [sactl_pkg::CNT_W-1:0]   miss_cnt_next;
    sactl_pkg::line_t              wr_line;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    sactl_addr_split #(
        .SETS_LOG2 (SETS_LOG2),
        .SET_W     (SET_W)
    ) u_addr_split (
        .address      (address),
        .offset_width (offset_w_reg),
        .index_width  (index_w_reg),
        .set_idx      (in_set),
        .tag          (in_tag)
    );

    assign wr_line.tag   = s1_tag_reg;
    assign wr_line.stamp = stamp_cnt_next;

    for (genvar w = 0; w < NUM_WAYS; w++)
    begin : g_way
        sactl_way_ram #(
            .SETS_LOG2 (SETS_LOG2),
            .SET_W     (SET_W)
        ) u_way_ram (
            .clk     (clk),
            .wr_en   (line_we && (pick_way == WAY_W'(w))),
            .wr_addr (s1_set_reg),
            .wr_data (wr_line),
            .rd_en   (accept),
            .rd_addr (in_set),
            .rd_data (rd_line[w])
        );

        assign eff_line[w] = (fwd_valid_reg && (fwd_set_reg == s1_set_reg) &&
                              (fwd_way_reg == WAY_W'(w))) ? fwd_line_reg : rd_line[w];
        assign eff_stamp[w] = eff_line[w].stamp;
        assign set_valid[w] = valid_reg[s1_set_reg][w];
        assign hit_vec[w]   = set_valid[w] && (eff_line[w].tag == s1_tag_reg);
    end

    sactl_victim #(
        .NUM_WAYS (NUM_WAYS),
        .WAY_W    (WAY_W)
    ) u_victim (
        .valid_vec (set_valid),
        .hit_vec   (hit_vec),
        .stamps    (eff_stamp),
        .hit       (pick_hit),
        .way       (pick_way)
    );

    assign do_access = s1_valid_reg && advance && (s1_cmd_reg == sactl_pkg::CMD_ACCESS);
    assign do_clear  = s1_valid_reg && advance && (s1_cmd_reg == sactl_pkg::CMD_CLEAR);
    assign stamp_req = do_access && (!pick_hit || (policy_reg == sactl_pkg::POLICY_LRU));
    assign line_we   = stamp_req;
    assign pick_way_wide = {2'b00, pick_way};

    always_comb
    begin
        stamp_cnt_next  = stamp_cnt_reg;
        overflow_next   = overflow_reg;
        access_cnt_next = access_cnt_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        if (stamp_req)
        begin
            if (stamp_cnt_reg == sactl_pkg::STAMP_MAX)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                stamp_cnt_next = stamp_cnt_reg + 1'b1;
            end
        end
        if (do_access)
        begin
            if (access_cnt_reg != sactl_pkg::CNT_MAX)
            begin
                access_cnt_next = access_cnt_reg + 1'b1;
            end
            if (pick_hit && (hit_cnt_reg != sactl_pkg::CNT_MAX))
            begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
            if (!pick_hit && (miss_cnt_reg != sactl_pkg::CNT_MAX))
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
        if (do_clear)
        begin
            stamp_cnt_next  = '0;
            overflow_next   = 1'b0;
            access_cnt_next = '0;
            hit_cnt_next    = '0;
            miss_cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= sactl_pkg::RST_POLICY;
            offset_w_reg <= sactl_pkg::RST_OFFSET_WIDTH;
            index_w_reg  <= sactl_pkg::RST_INDEX_WIDTH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sactl_pkg::REG_POLICY:       policy_reg   <= cfg_data[0];
                sactl_pkg::REG_OFFSET_WIDTH: offset_w_reg <= cfg_data[3:0];
                sactl_pkg::REG_INDEX_WIDTH:  index_w_reg  <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (line_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SET_COUNT; s++)
            begin
                valid_reg[s] <= '0;
            end
            stamp_cnt_reg  <= '0;
            access_cnt_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            if (do_clear)
            begin
                for (int s = 0; s < SET_COUNT; s++)
                begin
                    valid_reg[s] <= '0;
                end
            end
            else if (line_we)
            begin
                valid_reg[s1_set_reg][pick_way] <= 1'b1;
            end
            stamp_cnt_reg  <= stamp_cnt_next;
            access_cnt_reg <= access_cnt_next;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            overflow_reg   <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= command;
            s1_set_reg <= in_set;
            s1_tag_reg <= in_tag;
        end
        if (line_we)
        begin
            fwd_set_reg  <= s1_set_reg;
            fwd_way_reg  <= pick_way;
            fwd_line_reg <= wr_line;
        end
        if (advance && s1_valid_reg)
        begin
            hit_reg          <= do_access && pick_hit;
            way_used_reg     <= do_access ? pick_way_wide[1:0] : 2'b00;
            access_total_reg <= access_cnt_next;
            hit_total_reg    <= hit_cnt_next;
            miss_total_reg   <= miss_cnt_next;
            overflow_out_reg <= overflow_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign way_used       = way_used_reg;
    assign access_total   = access_total_reg;
    assign hit_total      = hit_total_reg;
    assign miss_total     = miss_total_reg;
    assign stamp_overflow = overflow_out_reg;

endmodule

### hw/rtl/sactl_checker.sv
// ----------------------------------------------------------------------------
// sactl_checker
// Port-level checks of the tag lookup, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_lookup_macros.svh"

module sactl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        hit,
    input logic [1:0]                  way_used,
    input logic [sactl_pkg::CNT_W-1:0] access_total,
    input logic [sactl_pkg::CNT_W-1:0] hit_total,
    input logic [sactl_pkg::CNT_W-1:0] miss_total,
    input logic                        stamp_overflow
);

    // A result held back by the consumer stays put.
    `SACTL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(way_used) && $stable(access_total) && $stable(hit_total) && $stable(miss_total) && $stable(stamp_overflow), "stalled result changed")

    // The input side is only held back while the output side is stalled.
    `SACTL_ASSERT_SAME(a_no_idle_stall, !out_stall, !in_stall, "input stalled while output free")

    // A hit is always counted as both an access and a hit.
    `SACTL_ASSERT_SAME(a_hit_counted, out_valid && hit, (hit_total != '0) && (access_total != '0), "hit without counts")

    // Every counted access is either a hit or a miss.
    `SACTL_ASSERT_SAME(a_totals_agree, out_valid && (hit_total == '0) && (miss_total == '0), access_total == '0, "access count without hit or miss")

endmodule

bind set_assoc_cache_tag_lookup sactl_checker u_sactl_checker (.*);
